/* rtl/alternating_sweep_disk_scheduler_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the alternating-sweep disk scheduler
// Shared concurrent assertion forms, clocked on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ALTERNATING_SWEEP_DISK_SCHEDULER_MACROS_SVH
`define ALTERNATING_SWEEP_DISK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define ASDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/asds_pkg.sv */
// ----------------------------------------------------------------------------
// asds_pkg
// Shared constants, status codes and the result record of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package asds_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int AW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);

  localparam int LOC_W  = 30;
  localparam int PID_W  = 16;
  localparam int TIME_W = 32;
  localparam int SVC_W  = 8;
  localparam int KEY_W  = LOC_W + PID_W;
  localparam int DATA_W = 80;

  localparam logic [SVC_W-1:0] SERVICE_TIME_RESET = 8'd5;

  localparam logic       REQ_ADD     = 1'b0;
  localparam logic       REQ_SERVICE = 1'b1;

  localparam logic [1:0] ST_SERVED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic [PID_W-1:0]  pid;
    logic [LOC_W-1:0]  loc;
    logic [TIME_W-1:0] done_time;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/alternating_sweep_disk_scheduler.sv */
// Flow: an add beat is written straight into the request memory and gives no result;
//   a dropped add or an empty sweep goes through res_r into out_r, held in S_EMIT
//   while the output is busy. Each served request costs a full scan of the queue
//   through the one read port; in_tready stays low until the last result is in out_r.
// Reset (rst_n low, synchronous): queue empty, first sweep ascending, clock 0,
//   service time 5, output empty. The request memory is not cleared.
// ----------------------------------------------------------------------------
// alternating_sweep_disk_scheduler
// Elevator disk scheduler: queues requests in a memory and drains them in
// sweeps that alternate between ascending and descending location order.
// ----------------------------------------------------------------------------
`default_nettype none

module alternating_sweep_disk_scheduler
  import asds_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  // input stream
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire [DATA_W-1:0]  in_tdata,   // location[29:0], proc_id[45:30], now[77:46]
  input  wire               in_tuser,   // req_type
  // result stream
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [DATA_W-1:0] out_tdata,  // proc_id_out[15:0], location_out[45:16],
                                        // done_time[77:46]
  output logic [1:0]        out_tuser,  // status
  output logic              out_tlast,  // last
  // configuration
  input  wire               cfg_we,
  input  wire [SVC_W-1:0]   cfg_wdata   // service_time
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // take beats
  localparam logic [1:0] S_SCAN = 2'd1;  // stream the queue through the compare
  localparam logic [1:0] S_MOVE = 2'd2;  // last entry arrives, fill the hole
  localparam logic [1:0] S_EMIT = 2'd3;  // hand the result to the output stage

  // Request memory: word = {location, proc_id}, so the word itself is the sort key
  logic [KEY_W-1:0] mem [QUEUE_DEPTH];
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [KEY_W-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;

  logic [1:0]        state_r,   state_nxt;
  logic [CW-1:0]     count_r,   count_nxt;
  logic              desc_r,    desc_nxt;
  logic [TIME_W-1:0] clk_r,     clk_nxt;
  logic [SVC_W-1:0]  svc_r;
  logic [CW-1:0]     iss_r,     iss_nxt;     // next scan read address
  logic              rv_r,      rv_nxt;      // a scan read is returning
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt; // index of the returning read
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  res_t              res_r,     res_nxt;     // result waiting for the output stage
  res_t              out_r,     out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [LOC_W-1:0]  in_loc;
  logic [PID_W-1:0]  in_pid;
  logic [TIME_W-1:0] in_now;
  logic [CW-1:0]     last_idx;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] clk_raised;
  logic              better;
  logic              out_free;

  assign in_loc = in_tdata[LOC_W-1:0];
  assign in_pid = in_tdata[LOC_W+PID_W-1:LOC_W];
  assign in_now = in_tdata[LOC_W+PID_W+TIME_W-1:LOC_W+PID_W];

  assign last_idx   = count_r - CW'(1);
  assign sum        = {1'b0, clk_r} + {{(TIME_W+1-SVC_W){1'b0}}, svc_r};
  assign clk_raised = (in_now > clk_r) ? in_now : clk_r;
  assign better     = desc_r ? (rd_data_r > best_key_r) : (rd_data_r < best_key_r);
  assign out_free   = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {{(DATA_W-TIME_W-LOC_W-PID_W){1'b0}},
                       out_r.done_time, out_r.loc, out_r.pid};

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    desc_nxt      = desc_r;
    clk_nxt       = clk_r;
    iss_nxt       = iss_r;
    rv_nxt        = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_idx_nxt  = best_idx_r;
    best_key_nxt  = best_key_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_re        = 1'b0;
    mem_raddr     = iss_r[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = {in_loc, in_pid};

    // Output stage drains independently of the sequencer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == REQ_ADD) begin
            if (count_r != CW'(QUEUE_DEPTH)) begin
              // append at the tail
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              // full: report the dropped request, clock untouched
              res_nxt   = '{status: ST_DROPPED, pid: in_pid, loc: in_loc,
                            done_time: clk_r, last: 1'b1};
              state_nxt = S_EMIT;
            end
          end else begin
            clk_nxt = clk_raised;
            if (count_r == '0) begin
              res_nxt   = '{status: ST_EMPTY, pid: '0, loc: '0,
                            done_time: clk_raised, last: 1'b1};
              desc_nxt  = !desc_r;
              state_nxt = S_EMIT;
            end else begin
              iss_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // fold the returning entry into the running best
        if (rv_r && (cmp_idx_r == '0 || better)) begin
          best_idx_nxt = cmp_idx_r;
          best_key_nxt = rd_data_r;
        end
        if (iss_r < count_r) begin
          mem_re      = 1'b1;
          rv_nxt      = 1'b1;
          cmp_idx_nxt = iss_r[AW-1:0];
          iss_nxt     = iss_r + CW'(1);
        end else if (!rv_r) begin
          // scan done: fetch the tail entry to fill the hole
          mem_re    = 1'b1;
          mem_raddr = last_idx[AW-1:0];
          state_nxt = S_MOVE;
        end
      end

      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx_r;
        mem_wdata = rd_data_r;
        count_nxt = last_idx;
        clk_nxt   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        res_nxt   = '{status: ST_SERVED,
                      pid: best_key_r[PID_W-1:0],
                      loc: best_key_r[KEY_W-1:PID_W],
                      done_time: clk_nxt,
                      last: (last_idx == '0)};
        if (last_idx == '0) begin
          desc_nxt = !desc_r;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // hold until the output register frees up
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            iss_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      desc_r      <= 1'b0;
      clk_r       <= '0;
      svc_r       <= SERVICE_TIME_RESET;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      desc_r      <= desc_nxt;
      clk_r       <= clk_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        svc_r <= cfg_wdata;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule

`default_nettype wire

/* rtl/asds_checker.sv */
// ----------------------------------------------------------------------------
// asds_checker
// Port-level checks on the scheduler's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alternating_sweep_disk_scheduler_macros.svh"

module asds_checker
  import asds_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              out_tvalid,
  input wire              out_tready,
  input wire [DATA_W-1:0] out_tdata,
  input wire [1:0]        out_tuser,
  input wire              out_tlast
);

  `ASDS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "stalled result beat changed")
  `ASDS_ASSERT_NOW(a_status_code, out_tvalid,
    out_tuser == ST_SERVED || out_tuser == ST_DROPPED || out_tuser == ST_EMPTY,
    "undefined status code")
  `ASDS_ASSERT_NOW(a_empty_beat, out_tvalid && out_tuser == ST_EMPTY,
    out_tlast && out_tdata[LOC_W+PID_W-1:0] == '0,
    "empty sweep beat not final or carries a request")
  `ASDS_ASSERT_NOW(a_drop_last, out_tvalid && out_tuser == ST_DROPPED, out_tlast,
    "dropped-add beat not marked last")

endmodule

bind alternating_sweep_disk_scheduler asds_checker u_asds_checker (.*);

`default_nettype wire

/* verif/sweep_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sweep_result_checker
// Watches the request, result and configuration ports of the disk scheduler,
// keeps its own copy of the request queue, disk clock and sweep direction,
// and compares every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module sweep_result_checker
  import asds_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  input  wire              in_tready,
  input  wire [DATA_W-1:0] in_tdata,    // location[29:0], proc_id[45:30], now[77:46]
  input  wire              in_tuser,    // req_type
  input  wire              out_tvalid,
  input  wire              out_tready,
  input  wire [DATA_W-1:0] out_tdata,   // proc_id_out[15:0], location_out[45:16],
                                        // done_time[77:46]
  input  wire [1:0]        out_tuser,   // status
  input  wire              out_tlast,   // last
  input  wire              cfg_we,
  input  wire [SVC_W-1:0]  cfg_wdata,   // service_time
  output int               fail_count,
  output int               results_pending
);

  localparam int REPORT_LIMIT = 40;

  logic [LOC_W-1:0]  queued_loc [QUEUE_DEPTH];
  logic [PID_W-1:0]  queued_pid [QUEUE_DEPTH];
  int                queued_count;
  logic              descending;
  logic [TIME_W-1:0] disk_clock;
  logic [SVC_W-1:0]  service_ticks;
  res_t              due_results [$];

  initial begin
    fail_count      = 0;
    results_pending = 0;
  end

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Queue an add (or drop it when the queue is full), or drain the whole queue in the current direction.
  task automatic predict_results(input logic req, input logic [LOC_W-1:0] loc,
                                 input logic [PID_W-1:0] pid,
                                 input logic [TIME_W-1:0] now);
    res_t            r;
    int              best;
    logic [TIME_W:0] sum;
    if (req == REQ_ADD) begin
      if (queued_count < QUEUE_DEPTH) begin
        queued_loc[queued_count] = loc;
        queued_pid[queued_count] = pid;
        queued_count++;
      end else begin
        r.status    = ST_DROPPED;
        r.pid       = pid;
        r.loc       = loc;
        r.done_time = disk_clock;
        r.last      = 1'b1;
        due_results.push_back(r);
      end
    end else begin
      if (now > disk_clock)
        disk_clock = now;
      if (queued_count == 0) begin
        r.status    = ST_EMPTY;
        r.pid       = '0;
        r.loc       = '0;
        r.done_time = disk_clock;
        r.last      = 1'b1;
        due_results.push_back(r);
      end
      while (queued_count > 0) begin
        best = 0;
        for (int i = 1; i < queued_count; i++) begin
          if (descending ? ({queued_loc[i], queued_pid[i]} > {queued_loc[best], queued_pid[best]})
                         : ({queued_loc[i], queued_pid[i]} < {queued_loc[best], queued_pid[best]}))
            best = i;
        end
        r.status = ST_SERVED;
        r.pid    = queued_pid[best];
        r.loc    = queued_loc[best];
        queued_count--;
        queued_loc[best] = queued_loc[queued_count];
        queued_pid[best] = queued_pid[queued_count];
        sum = {1'b0, disk_clock} + {{(TIME_W+1-SVC_W){1'b0}}, service_ticks};
        disk_clock  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        r.done_time = disk_clock;
        r.last      = (queued_count == 0);
        due_results.push_back(r);
      end
      descending = ~descending;
    end
  endtask

  task automatic check_result();
    res_t              want;
    logic [PID_W-1:0]  got_pid;
    logic [LOC_W-1:0]  got_loc;
    logic [TIME_W-1:0] got_time;
    got_pid  = out_tdata[PID_W-1:0];
    got_loc  = out_tdata[PID_W +: LOC_W];
    got_time = out_tdata[PID_W+LOC_W +: TIME_W];
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: result beat, expected none, actual status %0d pid %0h loc %0h time %0h",
                 $time, out_tuser, got_pid, got_loc, got_time);
      return;
    end
    want = due_results.pop_front();
    if (out_tuser != want.status)   note_mismatch("status", want.status, out_tuser);
    if (got_pid != want.pid)        note_mismatch("proc_id_out", want.pid, got_pid);
    if (got_loc != want.loc)        note_mismatch("location_out", want.loc, got_loc);
    if (got_time != want.done_time) note_mismatch("done_time", want.done_time, got_time);
    if (out_tlast != want.last)     note_mismatch("last", want.last, out_tlast);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      queued_count  = 0;
      descending    = 1'b0;
      disk_clock    = '0;
      service_ticks = SERVICE_TIME_RESET;
      due_results.delete();
    end else begin
      // a request beat is never answered at the edge that accepts it
      if (out_tvalid && out_tready)
        check_result();
      if (in_tvalid && in_tready)
        predict_results(in_tuser, in_tdata[LOC_W-1:0], in_tdata[LOC_W +: PID_W],
                        in_tdata[LOC_W+PID_W +: TIME_W]);
      if (cfg_we)
        service_ticks = cfg_wdata;
    end
    results_pending = due_results.size();
  end

endmodule

/* verif/alternating_sweep_disk_scheduler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_sweep_disk_scheduler_tb
// Drives add and service beats into the scheduler with random gaps on both
// streams, changes the service time between phases, and lets the checker
// judge every result beat; a stall watchdog bounds the run.
// ----------------------------------------------------------------------------
module alternating_sweep_disk_scheduler_tb;
  import asds_pkg::*;

  localparam int STALL_LIMIT   = 20000;  // cycles without any beat before giving up
  localparam int SETTLE_CYCLES = 8;      // covers the store of an add beat

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [DATA_W-1:0] out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_we;
  logic [SVC_W-1:0]  cfg_wdata;

  int                fail_count;
  int                results_pending;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                quiet_cycles  = 0;
  logic [TIME_W-1:0] now_base;
  logic [SVC_W-1:0]  svc_pick;

  alternating_sweep_disk_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sweep_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: drop ready at random for the current share of cycles.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any beat on any port restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat after a random gap and hold it until accepted.
  task automatic send_beat(input logic req, input logic [LOC_W-1:0] loc,
                           input logic [PID_W-1:0] pid, input logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, now, pid, loc};
    do @(posedge clk); while (!in_tready);
  endtask

  // Lower valid and hold off until every predicted result beat has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // Write the service time only with the scheduler idle.
  task automatic set_service_time(input logic [SVC_W-1:0] ticks);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly random locations, with a small pool so that equal keys come up.
  function automatic logic [LOC_W-1:0] pick_location();
    logic [31:0] rnd;
    rnd = $urandom();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {28'h40, rnd[1:0]};
      default: return rnd[LOC_W-1:0];
    endcase
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    logic [31:0] rnd;
    rnd = $urandom();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {14'h0, rnd[1:0]};
      default: return rnd[PID_W-1:0];
    endcase
  endfunction

  // Keep request times low and mostly rising so the disk clock stays far
  // from saturation until the last phase; sometimes lag behind it.
  function automatic logic [TIME_W-1:0] pick_now();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom_range(now_base);
      default: begin
        now_base = now_base + $urandom_range(20000);
        return now_base;
      end
    endcase
  endfunction

  // Queue a number of requests, then sweep them out.
  task automatic run_batch(input int adds, input logic [TIME_W-1:0] now);
    logic [31:0] rnd;
    repeat (adds) begin
      rnd = $urandom();
      send_beat(REQ_ADD, pick_location(), pick_pid(), rnd);
    end
    rnd = $urandom();
    send_beat(REQ_SERVICE, rnd[LOC_W-1:0], pick_pid(), now);
  endtask

  // Mostly short batches; now and then a long one that can overfill the queue.
  task automatic run_batches(input int items);
    int adds;
    while (items > 0) begin
      adds = ($urandom_range(11) == 0) ? $urandom_range(70, 60) : $urandom_range(10);
      run_batch(adds, pick_now());
      items -= adds + 1;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_ADD;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    now_base  = 32'd2000;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver heavily.
    send_idle_pct = 20;
    recv_idle_pct = 50;

    // Empty sweeps right after reset, one in each direction; the second
    // raises the clock and carries junk in its unused fields.
    send_beat(REQ_SERVICE, '0, '0, '0);
    send_beat(REQ_SERVICE, '1, '1, 32'd16);
    // Key extremes, a shared location with two ids, and a duplicate key.
    send_beat(REQ_ADD, '1, '1, '1);
    send_beat(REQ_ADD, '0, '0, '0);
    send_beat(REQ_ADD, 30'h155, 16'd7, '0);
    send_beat(REQ_ADD, 30'h155, 16'd3, '0);
    send_beat(REQ_ADD, 30'h155, 16'd3, '0);
    send_beat(REQ_ADD, 30'h2AAAAAAA, 16'h5555, 32'hAAAA5555);
    send_beat(REQ_SERVICE, '0, '0, 32'd1000);  // ascending sweep
    send_beat(REQ_ADD, 30'h15555555, 16'hAAAA, 32'h5555AAAA);
    send_beat(REQ_ADD, 30'h155, 16'd3, '0);
    send_beat(REQ_ADD, 30'h3FFFFFFE, 16'hFFFF, '0);
    // Time behind the clock: keep the clock, sweep downward.
    send_beat(REQ_SERVICE, '0, '0, 32'd5);
    send_beat(REQ_SERVICE, '0, '0, 32'd0);     // empty, clock unchanged

    // A service time of 1; overfill the queue so adds get dropped, then a
    // full sweep of the deepest queue.
    set_service_time(8'd1);
    run_batch(QUEUE_DEPTH + 2, pick_now());
    run_batches(80);

    // Phase two: the other way round, with the longest and a zero service time.
    set_service_time(8'd255);
    send_idle_pct = 50;
    recv_idle_pct = 20;
    run_batches(80);
    set_service_time(8'd0);
    run_batches(12);

    // Phase three: no idling at all.
    svc_pick = SVC_W'($urandom_range(254, 2));
    set_service_time(svc_pick);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_batches(70);

    // Push the clock into saturation last, since it never comes back down.
    set_service_time(8'd255);
    run_batch(3, 32'hFFFF_FF00);
    run_batch(0, 32'hFFFF_FFFF);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
